>>> rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define LRTC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lrtc check failed");

// next-cycle implication, sampled on clock, off during reset
`define LRTC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lrtc check failed");

`endif

>>> rtl/lrtc_pkg.sv
// types, constants and the rounding function of the render target cache
package lrtc_pkg;

   localparam int MAX_KEPT     = 10;
   localparam int DIM_W        = 15;
   localparam int SAMPLES_W    = 7;
   localparam int SLOT_FIELD_W = 4;

   typedef struct packed {
      logic [DIM_W-1:0]     request_width;
      logic [DIM_W-1:0]     request_height;
      logic [SAMPLES_W-1:0] request_samples;
      logic                 create_ok;
   } lrtc_req_type;

   typedef struct packed {
      logic                    hit;
      logic                    failed;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [DIM_W-1:0]        rounded_width;
      logic [DIM_W-1:0]        rounded_height;
      logic                    evicted;
      logic [SLOT_FIELD_W-1:0] evicted_slot;
   } lrtc_rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]     width;
      logic [DIM_W-1:0]     height;
      logic [SAMPLES_W-1:0] samples;
   } lrtc_key_type;

   typedef struct packed {
      logic take_left;
      logic drop;
   } lrtc_cell_ctl_type;

   // round up to a power of two, modulo 2^DIM_W
   function automatic logic [DIM_W-1:0] round_pow2(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] x;
      x = v - DIM_W'(1);
      x = x | (x >> 1);
      x = x | (x >> 2);
      x = x | (x >> 4);
      x = x | (x >> 8);
      return x + DIM_W'(1);
   endfunction

endpackage

>>> rtl/lrtc_cell.sv
// one recency position: holds a slot number and its key, shifts from its left neighbor
module lrtc_cell
   import lrtc_pkg::*;
#(
   parameter int SLOT_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  lrtc_cell_ctl_type ctl,
   input  lrtc_key_type      lookup_key,
   input  logic              left_valid,
   input  logic [SLOT_W-1:0] left_slot,
   input  lrtc_key_type      left_key,
   output logic              valid,
   output logic [SLOT_W-1:0] slot,
   output lrtc_key_type      key,
   output logic              match
);

   logic              valid_ff;
   logic              valid_in;
   logic [SLOT_W-1:0] slot_ff;
   lrtc_key_type      key_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.drop) begin
         valid_in = 1'b0;
      end else if (ctl.take_left) begin
         valid_in = left_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take_left && !ctl.drop) begin
         slot_ff <= left_slot;
         key_ff  <= left_key;
      end
   end

   assign valid = valid_ff;
   assign slot  = slot_ff;
   assign key   = key_ff;
   assign match = valid_ff && (key_ff == lookup_key);

endmodule

>>> rtl/lru_render_target_cache_unit.sv
// render target cache: most-recent-first chain of cells with lookup and move to front
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  lrtc_req_type
//   rsp       out        rsp_valid/rsp_stall  lrtc_rsp_type
//
// a request first registers the rounded key, then does the compare
// across all cells and the shift of the chain
// reset empties the chain by clearing each cell's valid bit, no clearing pass
// while a request is in work req_stall is high; the chain updates only when the
// response register is free or being taken, so rsp_stall delays the update
module lru_render_target_cache_unit
   import lrtc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lrtc_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lrtc_rsp_type rsp_payload
);

   localparam int SLOTS  = MAX_KEPT + 1;
   localparam int SLOT_W = $clog2(SLOTS);

   logic              pend_ff;
   logic              pend_in;
   lrtc_key_type      key_ff;
   logic              ok_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   lrtc_rsp_type      rsp_ff;
   lrtc_rsp_type      rsp_in;

   logic              accept;
   logic              fire;

   logic              cell_valid [SLOTS];
   logic [SLOT_W-1:0] cell_slot  [SLOTS];
   lrtc_key_type      cell_key   [SLOTS];
   logic              left_valid [SLOTS];
   logic [SLOT_W-1:0] left_slot  [SLOTS];
   lrtc_key_type      left_key   [SLOTS];
   lrtc_cell_ctl_type cell_ctl   [SLOTS];
   logic [SLOTS-1:0]  match;

   logic [SLOTS-1:0]  first;
   logic [SLOTS-1:0]  mask_le;
   logic              hit;
   logic              full;
   logic              evict;
   logic [SLOT_W-1:0] hit_slot;
   logic [SLOTS-1:0]  used;
   logic [SLOTS-1:0]  free_onehot;
   logic [SLOT_W-1:0] free_slot;
   logic [SLOT_W-1:0] front_slot;

   assign accept    = req_valid && !pend_ff;
   assign fire      = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_ff;

   // lookup and free slot search
   always_comb begin
      hit_slot  = '0;
      free_slot = '0;
      used      = '0;
      hit       = |match;
      full      = cell_valid[SLOTS-1];
      evict     = !hit && full;
      first     = match & (~match + SLOTS'(1));
      mask_le   = first | (first - SLOTS'(1));
      for (int i = 0; i < SLOTS; i++) begin
         if (first[i]) begin
            hit_slot = hit_slot | cell_slot[i];
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         for (int j = 0; j < SLOTS; j++) begin
            if (cell_valid[i] && !(evict && i == SLOTS - 1)
                && cell_slot[i] == SLOT_W'(j)) begin
               used[j] = 1'b1;
            end
         end
      end
      free_onehot = ~used & (used + SLOTS'(1));
      for (int j = 0; j < SLOTS; j++) begin
         if (free_onehot[j]) begin
            free_slot = free_slot | SLOT_W'(j);
         end
      end
      front_slot = hit ? hit_slot : free_slot;
   end

   // chain wiring and per-cell commands
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         if (i == 0) begin
            left_valid[i] = 1'b1;
            left_slot[i]  = front_slot;
            left_key[i]   = key_ff;
         end else begin
            left_valid[i] = cell_valid[i-1];
            left_slot[i]  = cell_slot[i-1];
            left_key[i]   = cell_key[i-1];
         end
         cell_ctl[i].take_left = fire && (hit ? mask_le[i] : ok_ff);
         cell_ctl[i].drop      = fire && evict && !ok_ff && (i == SLOTS - 1);
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      lrtc_cell #(
         .SLOT_W(SLOT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[g]),
         .lookup_key (key_ff),
         .left_valid (left_valid[g]),
         .left_slot  (left_slot[g]),
         .left_key   (left_key[g]),
         .valid      (cell_valid[g]),
         .slot       (cell_slot[g]),
         .key        (cell_key[g]),
         .match      (match[g])
      );
   end

   // response build
   always_comb begin
      rsp_in                = rsp_ff;
      rsp_in.hit            = hit;
      rsp_in.failed         = !hit && !ok_ff;
      rsp_in.slot           = (hit || ok_ff) ? SLOT_FIELD_W'(front_slot) : '0;
      rsp_in.rounded_width  = key_ff.width;
      rsp_in.rounded_height = key_ff.height;
      rsp_in.evicted        = evict;
      rsp_in.evicted_slot   = evict ? SLOT_FIELD_W'(cell_slot[SLOTS-1]) : '0;
   end

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (fire) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff.width   <= round_pow2(req_payload.request_width);
         key_ff.height  <= round_pow2(req_payload.request_height);
         key_ff.samples <= req_payload.request_samples;
         ok_ff          <= req_payload.create_ok;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/lrtc_checker.sv
// port-level checks for the render target cache, bound to the top level
`include "assert_macros.svh"

module lrtc_checker
   import lrtc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input lrtc_req_type req_payload,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input lrtc_rsp_type rsp_payload
);

   logic req_taken;

   assign req_taken = req_valid && !req_stall && (req_payload.create_ok || !req_payload.create_ok);

   `LRTC_ASSERT_SAME(a_hit_clean, rsp_valid && rsp_payload.hit, !rsp_payload.failed && !rsp_payload.evicted)
   `LRTC_ASSERT_SAME(a_failed_slot, rsp_valid && rsp_payload.failed, rsp_payload.slot == '0)
   `LRTC_ASSERT_SAME(a_no_evict_slot, rsp_valid && !rsp_payload.evicted, rsp_payload.evicted_slot == '0)
   `LRTC_ASSERT_NEXT(a_busy_after_take, req_taken, req_stall)
   `LRTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind lru_render_target_cache_unit lrtc_checker u_checker (.*);

>>> tb/sv/lrtc_cache_checker.sv
// response checker for the render target cache: predicts each response and compares it
module lrtc_cache_checker
   import lrtc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  lrtc_req_type req_payload,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  lrtc_rsp_type rsp_payload,
   output int           error_count,
   output int           pending_count
);

   localparam int SLOTS        = MAX_KEPT + 1;
   localparam int MAX_DIM      = 1 << (DIM_W - 1);
   localparam int REPORT_LIMIT = 10;

   lrtc_key_type            held_key [SLOTS];
   logic [SLOT_FIELD_W-1:0] recency [SLOTS];
   int                      held_count;
   lrtc_rsp_type            expected_rsp [$];

   function automatic logic [DIM_W-1:0] pow2_ceiling(input logic [DIM_W-1:0] v);
      logic [DIM_W:0] p;
      if (v == '0 || int'(v) > MAX_DIM) return '0;
      p = 1;
      while (p < v) p = p << 1;
      return p[DIM_W-1:0];
   endfunction

   function automatic void move_to_front(input int pos, input logic [SLOT_FIELD_W-1:0] s);
      for (int i = pos; i > 0; i--) recency[i] = recency[i-1];
      recency[0] = s;
   endfunction

   function automatic lrtc_rsp_type serve_request(input lrtc_req_type r);
      lrtc_rsp_type res;
      lrtc_key_type k;
      logic [SLOTS-1:0] used;
      int pos;
      int s;
      res = '0;
      k.width = pow2_ceiling(r.request_width);
      k.height = pow2_ceiling(r.request_height);
      k.samples = r.request_samples;
      res.rounded_width = k.width;
      res.rounded_height = k.height;
      pos = -1;
      for (int i = 0; i < held_count; i++) begin
         if (pos < 0 && held_key[recency[i]] == k) pos = i;
      end
      if (pos >= 0) begin
         res.hit = 1'b1;
         res.slot = recency[pos];
         move_to_front(pos, recency[pos]);
      end else begin
         if (held_count > MAX_KEPT) begin
            res.evicted = 1'b1;
            res.evicted_slot = recency[held_count-1];
            held_count--;
         end
         if (r.create_ok) begin
            used = '0;
            for (int i = 0; i < held_count; i++) used[recency[i]] = 1'b1;
            s = 0;
            while (s < SLOTS - 1 && used[s]) s++;
            held_key[s] = k;
            move_to_front(held_count, SLOT_FIELD_W'(s));
            held_count++;
            res.slot = SLOT_FIELD_W'(s);
         end else begin
            res.failed = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic string rsp_text(input lrtc_rsp_type r);
      return $sformatf("hit=%0d failed=%0d slot=%0d w=%0d h=%0d evicted=%0d evicted_slot=%0d",
                       r.hit, r.failed, r.slot, r.rounded_width, r.rounded_height,
                       r.evicted, r.evicted_slot);
   endfunction

   always @(posedge clock) begin : watch
      lrtc_rsp_type want;
      if (reset) begin
         held_count = 0;
         expected_rsp.delete();
         error_count = 0;
      end else begin
         if (req_valid && !req_stall) expected_rsp.push_back(serve_request(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("unexpected response: %s", rsp_text(rsp_payload));
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (want.hit !== rsp_payload.hit || want.failed !== rsp_payload.failed ||
                   want.slot !== rsp_payload.slot ||
                   want.rounded_width !== rsp_payload.rounded_width ||
                   want.rounded_height !== rsp_payload.rounded_height ||
                   want.evicted !== rsp_payload.evicted ||
                   want.evicted_slot !== rsp_payload.evicted_slot) begin
                  if (error_count < REPORT_LIMIT) begin
                     $display("response mismatch at %0t", $realtime);
                     $display("  expected %s", rsp_text(want));
                     $display("  actual   %s", rsp_text(rsp_payload));
                  end
                  error_count++;
               end
            end
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

>>> tb/sv/tb_lru_render_target_cache_unit.sv
// testbench top for the render target cache: stimulus, flow control and verdict
module tb_lru_render_target_cache_unit;
   import lrtc_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 500;
   localparam int POOL_SIZE    = 14;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_DIM      = 1 << (DIM_W - 1);
   localparam int DIM_TOP      = (1 << DIM_W) - 1;

   typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   lrtc_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   lrtc_rsp_type rsp_payload;
   int           error_count;
   int           pending_count;
   int           burst_left;
   int           hold_requests;
   int           cycle_count;

   logic [DIM_W-1:0]     pool_w [POOL_SIZE];
   logic [DIM_W-1:0]     pool_h [POOL_SIZE];
   logic [SAMPLES_W-1:0] pool_s [POOL_SIZE];

   always #(HALF_PERIOD) clock = ~clock;

   lru_render_target_cache_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   lrtc_cache_checker cache_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   function automatic lrtc_req_type make_req(input int w, input int h, input int s,
                                             input bit ok);
      lrtc_req_type r;
      r.request_width = DIM_W'(w);
      r.request_height = DIM_W'(h);
      r.request_samples = SAMPLES_W'(s);
      r.create_ok = ok;
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] pick_target();
      int e;
      e = $urandom_range(0, DIM_W);
      if (e == DIM_W) return '0;
      return DIM_W'(1 << e);
   endfunction

   // any width that rounds to the given power of two
   function automatic int spread(input logic [DIM_W-1:0] target);
      if (target == '0) return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_DIM + 1, DIM_TOP);
      if (target == 1) return 1;
      return $urandom_range(int'(target) / 2 + 1, int'(target));
   endfunction

   function automatic void refresh_pool(input int idx);
      pool_w[idx] = pick_target();
      pool_h[idx] = pick_target();
      if ($urandom_range(0, 7) == 0) pool_s[idx] = SAMPLES_W'($urandom_range(0, 127));
      else pool_s[idx] = ($urandom_range(0, 7) == 0) ? '0 : SAMPLES_W'(1 << $urandom_range(0, 6));
   endfunction

   function automatic lrtc_req_type pick_request();
      int idx;
      bit ok;
      ok = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 99) < 15)
         return make_req($urandom_range(0, DIM_TOP), $urandom_range(0, DIM_TOP),
                         $urandom_range(0, 127), ok);
      idx = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 15) == 0) refresh_pool(idx);
      return make_req(spread(pool_w[idx]), spread(pool_h[idx]), pool_s[idx], ok);
   endfunction

   task automatic offer(input lrtc_req_type item);
      int gap;
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // receiver flow control
   initial begin
      flow_mode_type mode;
      int span;
      int hold_left;
      int holds_served;
      logic stall_next;
      rsp_stall = 1'b0;
      mode = FLOW_FREE;
      span = 0;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests > holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            if (span <= 0) begin
               mode = flow_mode_type'($urandom_range(0, 3));
               span = $urandom_range(5, 60);
            end
            span--;
            case (mode)
               FLOW_FREE: begin
                  stall_next = 1'b0;
               end
               FLOW_LIGHT: begin
                  stall_next = ($urandom_range(0, 9) < 3);
               end
               FLOW_HEAVY: begin
                  stall_next = ($urandom_range(0, 9) < 7);
               end
               default: begin
                  stall_next = (span % 3 == 0);
               end
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_lru_render_target_cache_unit NOT OK");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      hold_requests = 0;
      burst_left = $urandom_range(1, 24);
      for (int i = 0; i < POOL_SIZE; i++) refresh_pool(i);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // failed miss on an empty cache
      offer(make_req(1, 1, 0, 1'b0));
      // fill every slot, zero and oversized dimensions among them
      offer(make_req(1, 1, 0, 1'b1));
      offer(make_req(16384, 16384, 64, 1'b1));
      offer(make_req(0, 5, 127, 1'b1));
      offer(make_req(16385, 3, 1, 1'b1));
      offer(make_req(32767, 32767, 2, 1'b1));
      offer(make_req(2, 16383, 4, 1'b1));
      offer(make_req(3, 100, 8, 1'b1));
      offer(make_req(1000, 1, 16, 1'b1));
      offer(make_req(4096, 4097, 32, 1'b1));
      offer(make_req(7, 7, 0, 1'b1));
      offer(make_req(9, 9, 1, 1'b1));
      // hits on the oldest and on a middle entry
      offer(make_req(1, 1, 0, 1'b1));
      offer(make_req(20000, 4, 1, 1'b0));
      // eviction with failed creation, then refill, then eviction with creation, then a hit on it
      offer(make_req(5, 6, 9, 1'b0));
      offer(make_req(5, 6, 9, 1'b1));
      offer(make_req(10922, 21845, 85, 1'b1));
      offer(make_req(10922, 21845, 85, 1'b0));
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 150 || i == 380) hold_requests++;
         if (i == 260) drain();
         offer(pick_request());
      end
      drain();
      repeat (8) @(negedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("tb_lru_render_target_cache_unit OK");
      end else begin
         $display("tb_lru_render_target_cache_unit NOT OK");
      end
      $finish;
   end

endmodule

>>> lru_render_target_cache_unit.f
+incdir+rtl
rtl/lrtc_pkg.sv
rtl/lrtc_cell.sv
rtl/lru_render_target_cache_unit.sv
rtl/lrtc_checker.sv
tb/sv/lrtc_cache_checker.sv
tb/sv/tb_lru_render_target_cache_unit.sv
